// ----- design/bracket_matcher_with_separators_assert.svh -----
// assertion macros for the bracket matcher modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BRACKET_MATCHER_WITH_SEPARATORS_ASSERT_SVH
`define BRACKET_MATCHER_WITH_SEPARATORS_ASSERT_SVH
`ifndef SYNTH
`define BMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BMS_ASSERT(lbl, prop, msg)
`define BMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/bms_pkg.sv -----
// types and codes shared by the bracket matcher modules
// no dependencies
package bms_pkg;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned ARGS_W  = 11;
  localparam int unsigned KIND_W  = 2;

  localparam logic [3:0] CLS_OTHER        = 4'd0;
  localparam logic [3:0] CLS_SPACING      = 4'd1;
  localparam logic [3:0] CLS_OPEN_ROUND   = 4'd2;
  localparam logic [3:0] CLS_OPEN_SQUARE  = 4'd3;
  localparam logic [3:0] CLS_OPEN_CURLY   = 4'd4;
  localparam logic [3:0] CLS_CLOSE_ROUND  = 4'd5;
  localparam logic [3:0] CLS_CLOSE_SQUARE = 4'd6;
  localparam logic [3:0] CLS_CLOSE_CURLY  = 4'd7;
  localparam logic [3:0] CLS_SEPARATOR    = 4'd8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ROLE_SPACE = 3'd0,
    ROLE_PLAIN = 3'd1,
    ROLE_OPEN  = 3'd2,
    ROLE_CLOSE = 3'd3,
    ROLE_SEP   = 3'd4
  } role_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_SEP_OUT   = 3'd3,
    ST_UNCLOSED  = 3'd4,
    ST_CAPACITY  = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0] token_class;
    logic       last_token;
  } tok_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  partner_position;
    logic [2:0]        role;
    logic [ARGS_W-1:0] arg_count;
    logic [2:0]        status;
    logic              sequence_done;
    logic              sequence_ok;
  } res_out_t;

  // classified token passed from front to back
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    role_e             role;
    logic [KIND_W-1:0] kind;
    logic              over;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  cnt;
  } stack_entry_t;

endpackage

// ----- design/bms_front.sv -----
// front end: classifies tokens and hands out dense positions
// depends on bms_pkg
module bms_front #(
  parameter int unsigned MAX_TOKENS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bms_pkg::tok_in_t in_word_i,
  output logic             q_push_o,
  input  logic             q_full_i,
  output bms_pkg::item_t   q_item_o
);
  import bms_pkg::*;

  localparam int unsigned NpW = $clog2(MAX_TOKENS + 1);
  localparam logic [NpW-1:0] NpLimit = NpW'(MAX_TOKENS);
  localparam logic [NpW-1:0] NpLast  = NpW'(MAX_TOKENS - 1);

  logic           fire;
  logic [NpW-1:0] np_q, np_d;
  item_t          item;

  assign fire       = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = fire;
  assign q_item_o   = item;

  always_comb begin
    item.kind = '0;
    item.pos  = '0;
    item.over = 1'b0;
    item.last = in_word_i.last_token;
    np_d      = np_q;
    unique case (in_word_i.token_class) inside
      CLS_SPACING: begin
        item.role = ROLE_SPACE;
      end
      CLS_OPEN_ROUND, CLS_OPEN_SQUARE, CLS_OPEN_CURLY: begin
        item.role = ROLE_OPEN;
        item.kind = KIND_W'(in_word_i.token_class - CLS_OPEN_ROUND);
      end
      CLS_CLOSE_ROUND, CLS_CLOSE_SQUARE, CLS_CLOSE_CURLY: begin
        item.role = ROLE_CLOSE;
        item.kind = KIND_W'(in_word_i.token_class - CLS_CLOSE_ROUND);
      end
      CLS_SEPARATOR: begin
        item.role = ROLE_SEP;
      end
      default: begin
        item.role = ROLE_PLAIN;
      end
    endcase
    if (item.role != ROLE_SPACE) begin
      if (np_q >= NpLimit) begin
        item.over = 1'b1;
        item.pos  = POS_W'(NpLast);
      end else begin
        item.pos = POS_W'(np_q);
        np_d     = np_q + NpW'(1);
      end
    end
    if (in_word_i.last_token) begin
      np_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= '0;
    end else if (fire) begin
      np_q <= np_d;
    end
  end

endmodule

// ----- design/bms_fifo.sv -----
// two-entry queue between the front end and the stack engine
// depends on bms_pkg
module bms_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bms_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output bms_pkg::item_t head_item_o
);
  import bms_pkg::*;

  item_t      data_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = data_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/bms_back.sv -----
// stack engine: bracket stack with cached top and prefetched second entry,
// error latch and output register; depends on bms_pkg and the assert header
`include "bracket_matcher_with_separators_assert.svh"
module bms_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  bms_pkg::item_t    head_item_i,
  output logic              head_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bms_pkg::res_out_t out_word_o
);
  import bms_pkg::*;

  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam logic [SpW-1:0] SpFull = SpW'(STACK_DEPTH);

  stack_entry_t mem_q [STACK_DEPTH];
  stack_entry_t top_q, top_d, below_q;
  logic [SpW-1:0] sp_q, sp_d, sp_dec, rd_sub;
  status_e        err_q, err_d, err_cur;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic           wr_en;
  logic           fire;
  logic           out_valid_q;
  res_out_t       res_q, res_d;
  logic [POS_W-1:0]  partner;
  logic [ARGS_W-1:0] args;

  assign fire        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign head_pop_o  = fire;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;

  assign sp_dec  = sp_q - SpW'(1);
  assign wr_addr = sp_dec[AddrW-1:0];
  assign rd_sub  = sp_d - SpW'(2);
  assign rd_addr = rd_sub[AddrW-1:0];

  always_comb begin
    sp_d    = sp_q;
    top_d   = top_q;
    err_d   = err_q;
    err_cur = err_q;
    wr_en   = 1'b0;
    partner = '0;
    args    = '0;
    res_d   = res_q;
    if (fire) begin
      if (head_item_i.over && err_cur == ST_OK) begin
        err_cur = ST_CAPACITY;
      end
      case (head_item_i.role)
        ROLE_OPEN: begin
          if (err_cur == ST_OK) begin
            if (sp_q == SpFull) begin
              err_cur = ST_CAPACITY;
            end else begin
              wr_en     = (sp_q != '0);
              top_d.pos  = head_item_i.pos;
              top_d.kind = head_item_i.kind;
              top_d.cnt  = '0;
              sp_d      = sp_q + SpW'(1);
            end
          end
        end
        ROLE_CLOSE: begin
          if (err_cur == ST_OK) begin
            if (sp_q == '0) begin
              err_cur = ST_UNMATCHED;
            end else begin
              sp_d  = sp_dec;
              top_d = below_q;
              if (top_q.kind != head_item_i.kind) begin
                err_cur = ST_MISMATCH;
              end else begin
                partner = top_q.pos;
                args    = ARGS_W'(top_q.cnt) + ARGS_W'(1);
              end
            end
          end
        end
        ROLE_SEP: begin
          if (err_cur == ST_OK) begin
            if (sp_q == '0) begin
              err_cur = ST_SEP_OUT;
            end else begin
              partner = top_q.pos;
              if (top_q.cnt != CNT_MAX) begin
                top_d.cnt = top_q.cnt + CNT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
      if (head_item_i.last && sp_d != '0 && err_cur == ST_OK) begin
        err_cur = ST_UNCLOSED;
      end
      res_d.position         = head_item_i.pos;
      res_d.partner_position = partner;
      res_d.role             = head_item_i.role;
      res_d.arg_count        = args;
      res_d.status           = err_cur;
      res_d.sequence_done    = head_item_i.last;
      res_d.sequence_ok      = head_item_i.last && (err_cur == ST_OK);
      if (head_item_i.last) begin
        sp_d  = '0;
        err_d = ST_OK;
      end else begin
        err_d = err_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  // payload registers and stack memory, with write-through to the prefetch
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (fire) begin
      res_q <= res_d;
    end
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
    if (wr_en && wr_addr == rd_addr) begin
      below_q <= top_q;
    end else begin
      below_q <= mem_q[rd_addr];
    end
  end

  `BMS_ASSERT_ALWAYS(a_sp_bound, !rst_ni || sp_q <= SpFull, "stack pointer beyond depth")
  `BMS_ASSERT(a_seq_restart, fire && head_item_i.last |=> sp_q == '0 && err_q == ST_OK,
              "state not cleared after last token")
  `BMS_ASSERT(a_err_sticky, fire && !head_item_i.last && err_q != ST_OK |=> err_q == $past(err_q),
              "latched error changed inside a sequence")
  `BMS_ASSERT(a_stack_frozen, fire && err_q != ST_OK && !head_item_i.last |=> sp_q == $past(sp_q),
              "stack moved while an error is latched")

endmodule

// ----- design/bracket_matcher_with_separators.sv -----
// an accepted token word waits in the queue; its result word is registered
// when the stack engine pops it; one token word per cycle unless stalled,
// set by the stack update (cached top, second entry prefetched from stack memory)
// a two-entry queue decouples the classifier from the stack engine
// reset: asynchronous, clears positions, stack pointer, error latch and queue;
// the stack memory is not cleared and no clearing pass runs
module bracket_matcher_with_separators #(
  parameter int unsigned MAX_TOKENS  = 1024,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bms_pkg::tok_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bms_pkg::res_out_t out_word_o
);
  import bms_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  item_t q_in, q_head;

  bms_front #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full),
    .q_item_o  (q_in)
  );

  bms_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_valid),
    .head_item_o (q_head)
  );

  bms_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_item_i (q_head),
    .head_pop_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
